// ===== design/ansi_utf8_sequence_splitter_assert.svh =====
// Assertion macros used by the splitter RTL.
// Each checks on the rising edge of clk_i and is quiet while rst_ni is low.
`ifndef ANSI_UTF8_SEQUENCE_SPLITTER_ASSERT_SVH
`define ANSI_UTF8_SEQUENCE_SPLITTER_ASSERT_SVH

// Plain expression that must hold at every edge.
`define AUS_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication.
`define AUS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AUS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/aus_pkg.sv =====
// ----------------------------------------------------------------------------
// aus_pkg
// Shared types and constants of the terminal escape/UTF-8 sequence splitter.
// ----------------------------------------------------------------------------
package aus_pkg;

  // Width of the internal sequence length counter (4 to 32).
  localparam int unsigned CountWidth = 16;
  localparam logic [CountWidth-1:0] CntMax = '1;

  // Parser modes.
  localparam logic [3:0] ModeAscii = 4'd0;
  localparam logic [3:0] ModeUtf8  = 4'd1;
  localparam logic [3:0] ModeEsc   = 4'd2;
  localparam logic [3:0] ModeCsi1  = 4'd3;
  localparam logic [3:0] ModeCsi2  = 4'd4;
  localparam logic [3:0] ModeSs    = 4'd5;
  localparam logic [3:0] ModeNf    = 4'd6;
  localparam logic [3:0] ModeStr   = 4'd7;
  localparam logic [3:0] ModeStr2  = 4'd8;

  typedef enum logic [1:0] {
    StBusy     = 2'd0,
    StDone     = 2'd1,
    StEndClean = 2'd2,
    StEndError = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]            mode;
    logic [31:0]           cp;
    logic [2:0]            rem;
    logic [CountWidth-1:0] cnt;
    logic                  sie;
  } state_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        restart;
    status_e     status;
    logic [15:0] len;
  } res_t;

  localparam state_t StateReset = '{
    mode: ModeAscii,
    cp:   32'd0,
    rem:  3'd0,
    cnt:  '0,
    sie:  1'b0
  };

endpackage

// ===== design/aus_step.sv =====
// ----------------------------------------------------------------------------
// aus_step
// One parser step: next state and result for one byte or end-of-stream mark.
// ----------------------------------------------------------------------------
module aus_step (
  input  aus_pkg::state_t st_i,
  input  logic [7:0]      byte_i,
  input  logic            end_i,
  output aus_pkg::state_t st_o,
  output aus_pkg::res_t   res_o
);
  import aus_pkg::*;

  localparam logic [7:0] ChEsc   = 8'h1b;
  localparam logic [7:0] ChBel   = 8'h07;
  localparam logic [7:0] ChBsl   = 8'h5c;
  localparam logic [7:0] ChLbr   = 8'h5b;
  localparam logic [7:0] ChC2    = 8'hc2;
  localparam logic [7:0] ChSt    = 8'h9c;

  localparam logic [31:0] CpEsc  = 32'h0000_001b;
  localparam logic [31:0] CpCsi  = 32'h0000_009b;
  localparam logic [31:0] CpSs2  = 32'h0000_008e;
  localparam logic [31:0] CpSs3  = 32'h0000_008f;
  localparam logic [31:0] CpDcs  = 32'h0000_0090;
  localparam logic [31:0] CpSos  = 32'h0000_0098;
  localparam logic [31:0] CpOsc  = 32'h0000_009d;
  localparam logic [31:0] CpPm   = 32'h0000_009e;
  localparam logic [31:0] CpApc  = 32'h0000_009f;

  typedef struct packed {
    logic        done;
    logic        to_esc;
    logic        to_utf8;
    logic [31:0] cp;
    logic [2:0]  rem;
  } fb_t;

  function automatic logic in_rng(logic [7:0] c, logic [7:0] lo, logic [7:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  // Start-state decode of a byte.
  function automatic fb_t first_byte(logic [7:0] c);
    fb_t f;
    f = '0;
    if (!c[7]) begin
      f.to_esc = (c == ChEsc);
      f.done   = (c != ChEsc);
    end else if (c[6]) begin
      f.to_utf8 = 1'b1;
      if (c[5] == 1'b0) begin
        f.cp  = {27'd0, c[4:0]};
        f.rem = 3'd1;
      end else if (c[4] == 1'b0) begin
        f.cp  = {28'd0, c[3:0]};
        f.rem = 3'd2;
      end else if (c[3] == 1'b0) begin
        f.cp  = {29'd0, c[2:0]};
        f.rem = 3'd3;
      end else begin
        f.cp  = {30'd0, c[1:0]};
        f.rem = c[2] ? 3'd5 : 3'd4;
      end
    end
    return f;
  endfunction

  function automatic state_t start_at(state_t s, fb_t f);
    state_t r;
    r = s;
    r.mode = f.to_esc ? ModeEsc : (f.to_utf8 ? ModeUtf8 : ModeAscii);
    if (f.to_utf8) begin
      r.cp  = f.cp;
      r.rem = f.rem;
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_len(logic [CountWidth-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_ffff) ? 16'hffff : w[15:0];
  endfunction

  fb_t                   fb;
  state_t                st_n;
  logic                  done;
  logic                  bad;
  logic                  rst_seq;
  logic [31:0]           cp_n;
  logic [2:0]            rem_n;

  always_comb begin
    st_n    = st_i;
    done    = 1'b0;
    bad     = 1'b0;
    rst_seq = 1'b0;
    cp_n    = {st_i.cp[25:0], byte_i[5:0]};
    rem_n   = st_i.rem - 3'd1;
    fb      = first_byte(byte_i);
    res_o   = '0;

    if (end_i) begin
      res_o.status = (st_i.cnt != '0) ? StEndError : StEndClean;
      res_o.len    = sat_len(st_i.cnt);
      st_o         = StateReset;
    end else begin
      if (st_i.cnt != CntMax) begin
        st_n.cnt = st_i.cnt + 1'b1;
      end
      if (st_n.cnt == CountWidth'(2)) begin
        st_n.sie = (byte_i == ChEsc);
      end

      case (st_i.mode)
        ModeUtf8: begin
          if (byte_i[7:6] == 2'b10) begin
            st_n.cp  = cp_n;
            st_n.rem = rem_n;
            if (rem_n == 3'd0) begin
              case (cp_n)
                CpEsc:                           st_n.mode = ModeEsc;
                CpCsi:                           st_n.mode = ModeCsi1;
                CpSs2, CpSs3:                    st_n.mode = ModeSs;
                CpDcs, CpSos, CpOsc, CpPm, CpApc: st_n.mode = ModeStr;
                default:                         done = 1'b1;
              endcase
            end
          end else begin
            bad = 1'b1;
          end
        end
        ModeEsc: begin
          if (in_rng(byte_i, 8'h20, 8'h2f)) begin
            if (byte_i == 8'h20 || byte_i == 8'h23) st_n.mode = ModeNf;
            else done = 1'b1;
          end else if (in_rng(byte_i, 8'h30, 8'h3f)) begin
            done = 1'b1;
          end else if (in_rng(byte_i, 8'h40, 8'h5f)) begin
            case (byte_i)
              ChLbr:                               st_n.mode = ModeCsi1;
              8'h4e, 8'h4f:                        st_n.mode = ModeSs;
              8'h50, 8'h58, 8'h5d, 8'h5e, 8'h5f:   st_n.mode = ModeStr;
              default:                             done = 1'b1;
            endcase
          end else if (in_rng(byte_i, 8'h60, 8'h7e)) begin
            done = 1'b1;
          end else if (byte_i == ChEsc) begin
            // A third ESC closes a one-byte sequence.
            if (st_n.cnt >= CountWidth'(3)) begin
              done     = 1'b1;
              rst_seq  = 1'b1;
              st_n.cnt = CountWidth'(1);
            end
          end else begin
            done = 1'b1;
          end
        end
        ModeSs: done = 1'b1;
        ModeNf: begin
          if (in_rng(byte_i, 8'h30, 8'h7e)) done = 1'b1;
          else if (!in_rng(byte_i, 8'h20, 8'h2f)) bad = 1'b1;
        end
        ModeCsi1: begin
          if (in_rng(byte_i, 8'h20, 8'h2f)) begin
            st_n.mode = ModeCsi2;
          end else if (byte_i == ChLbr && (st_n.cnt == CountWidth'(3) ||
                       (st_n.cnt == CountWidth'(4) && st_n.sie))) begin
            st_n.mode = ModeCsi1;  // doubled bracket of a console function key
          end else if (in_rng(byte_i, 8'h40, 8'h7e)) begin
            done = 1'b1;
          end else if (!in_rng(byte_i, 8'h30, 8'h3f)) begin
            bad = 1'b1;
          end
        end
        ModeCsi2: begin
          if (in_rng(byte_i, 8'h40, 8'h7e)) done = 1'b1;
          else if (!in_rng(byte_i, 8'h20, 8'h2f)) bad = 1'b1;
        end
        ModeStr: begin
          if (byte_i == ChBel) done = 1'b1;
          else if (byte_i == ChEsc || byte_i == ChC2) st_n.mode = ModeStr2;
        end
        ModeStr2: begin
          if (byte_i == ChBel || byte_i == ChBsl || byte_i == ChSt) done = 1'b1;
          else st_n.mode = ModeStr;
        end
        default: begin
          st_n = start_at(st_n, fb);
          done = fb.done;
        end
      endcase

      if (bad) begin
        rst_seq  = 1'b1;
        st_n.cnt = CountWidth'(1);
        st_n     = start_at(st_n, fb);
        done     = fb.done;
      end

      res_o.data    = byte_i;
      res_o.restart = rst_seq;
      res_o.status  = done ? StDone : StBusy;
      res_o.len     = sat_len(st_n.cnt);

      if (done) begin
        st_n.mode = ModeAscii;
        st_n.cp   = 32'd0;
        st_n.rem  = 3'd0;
        st_n.cnt  = '0;
      end
      st_o = st_n;
    end
  end

endmodule

// ===== design/ansi_utf8_sequence_splitter.sv =====
// ----------------------------------------------------------------------------
// ansi_utf8_sequence_splitter
// Marks the end of each keystroke or control sequence in a terminal byte
// stream (ASCII, UTF-8, ESC/CSI/SS/Nf and BEL/ST terminated strings).
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i in_ready_o in_byte_i           | sink
//          | stream_end_i                              |
//  out     | out_valid_o out_ready_i out_byte_o        | source
//          | restart_o status_o seq_length_o           |
//
// One byte per cycle sustained while out_ready_i holds high; each transfer
// yields exactly one result, which passes through the input register and then
// the result register before it can leave.
// The parser state advances one step per byte that leaves the input register.
// rst_ni (async, active low) returns the parser to the start state and
// empties both registers.
// With the output stalled, one more byte waits in the input register; then
// in_ready_o drops until out_ready_i frees the result register.
module ansi_utf8_sequence_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        restart_o,
  output logic [1:0]  status_o,
  output logic [15:0] seq_length_o
);
  import aus_pkg::*;

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // Parser state and result register.
  state_t st_q;
  state_t st_d;
  res_t   res_d;
  res_t   out_q;
  logic   out_vld_q;

  // Move the held byte into the result register when that register is free
  // or is being emptied this cycle.
  logic advance;
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  aus_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .end_i  (in_end_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Capture payload on every transfer; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_end_q  <= stream_end_i;
    end
  end

  // Advance parser state only when a byte leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_byte_o   = out_q.data;
  assign restart_o    = out_q.restart;
  assign status_o     = out_q.status;
  assign seq_length_o = out_q.len;

  // A sequence ends on this step; the parser sits idle at the start state.
  logic seq_end;
  logic st_idle;
  assign seq_end = advance && (res_d.status != StBusy);
  assign st_idle = (st_q.cnt == '0) && (st_q.mode == ModeAscii);

`include "ansi_utf8_sequence_splitter_assert.svh"

  // A byte that leaves the input register always lands in the result register.
  `AUS_ASSERT_NXT(a_advance_fills, advance, out_vld_q, "result register not filled")
  // Any finished sequence leaves the parser idle at the start state.
  `AUS_ASSERT_NXT(a_done_clears, seq_end, st_idle, "state not cleared after sequence end")
  // Outside the start state at least one byte is pending.
  `AUS_ASSERT_IMP(a_mode_counts, st_q.mode != ModeAscii, st_q.cnt != '0, "mode with no count")
  // A restarted sequence is one byte long.
  `AUS_ASSERT_IMP(a_restart_len, out_valid_o && restart_o, seq_length_o == 16'd1, "bad restart")

endmodule
